>>> hdl/mrqs_pkg.sv
package mrqs_pkg;

  localparam int QueueDepthDefault = 16;
  localparam int LevelCountDefault = 5;

  // Operation codes carried in a request.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_YIELD  = 2'd2;
  // Unused code: no state change and an all-zero response.
  localparam logic [1:0] OP_NOP    = 2'd3;

  // Policy modes.
  localparam logic [1:0] MODE_FCFS = 2'd0;
  localparam logic [1:0] MODE_SRTF = 2'd1;
  localparam logic [1:0] MODE_PRIO = 2'd2;
  localparam logic [1:0] MODE_MLFQ = 2'd3;

  // Configuration register indices.
  localparam logic [0:0] CFG_POLICY_MODE  = 1'd0;
  localparam logic [0:0] CFG_QUANTUM_STEP = 1'd1;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         task_id;
    logic [7:0]         task_priority;
    logic [15:0]        remaining_time;
    logic [15:0]        last_tick;
    logic [7:0]         burst_used;
    logic signed [3:0]  queue_level;
  } req_t;

  typedef struct packed {
    logic               task_valid;
    logic [7:0]         out_task_id;
    logic [7:0]         out_priority;
    logic [15:0]        out_remaining;
    logic [15:0]        out_last_tick;
    logic [7:0]         out_burst_used;
    logic signed [3:0]  out_level;
    logic               give_way;
    logic               queue_full;
  } rsp_t;

  // One stored task.
  typedef struct packed {
    logic [7:0]         id;
    logic [7:0]         prio;
    logic [15:0]        rem;
    logic [15:0]        tick;
    logic [7:0]         burst;
    logic signed [3:0]  level;
  } entry_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture request
    logic scan_step;  // compare the entry read last cycle
    logic shift_step; // move one entry up or down
    logic finish;     // commit and build the response
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic need_scan;
    logic need_shift;
  } sts_t;

endpackage

>>> hdl/mrqs_datapath.sv
module mrqs_datapath
  import mrqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDefault,
  parameter int LEVEL_COUNT = LevelCountDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] policy_mode,
  input  logic [7:0] quantum_step,
  input  req_t       req,
  input  cmd_t       cmd,
  output sts_t       sts,
  output rsp_t       rsp
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int LW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int FW = $clog2(LEVEL_COUNT * QUEUE_DEPTH);

  // Ordered store: one walking read port plus a head read, one write port.
  entry_t             ord_mem [QUEUE_DEPTH];
  entry_t             ord_rd;
  logic   [AW-1:0]    ord_raddr;
  logic               ord_we;
  logic   [AW-1:0]    ord_waddr;
  entry_t             ord_wdata;
  logic   [CW-1:0]    ord_count;

  // Level FIFO store.
  entry_t             fifo_mem [LEVEL_COUNT * QUEUE_DEPTH];
  entry_t             fifo_rd;
  logic               fifo_we;
  logic   [FW-1:0]    fifo_waddr;
  logic   [FW-1:0]    fifo_raddr;
  logic   [AW-1:0]    heads  [LEVEL_COUNT];
  logic   [CW-1:0]    counts [LEVEL_COUNT];
  logic   [SW-1:0]    slot_sum;
  logic   [AW-1:0]    slot;

  // Request registers and scan state.
  req_t               r;
  entry_t             ent;
  logic   [CW-1:0]    pos;
  logic   [CW-1:0]    idx;
  logic               found;
  logic   [1:0]       phase;   // scan and shift progress counter for read latency

  // Feedback promotion and level selection.
  logic   [11:0]      quantum;
  logic               promote;
  logic signed [4:0]  lvl_p;
  logic   [LW-1:0]    ins_lvl;
  logic               any_nonempty;
  logic   [LW-1:0]    pop_lvl;
  logic               lower_busy;
  logic               use_fifo;

  // Head capture, yield answer and response.
  entry_t             head_q;
  logic               yield_q;
  logic               yield_next;
  rsp_t               rsp_next;

  always_comb begin
    quantum = 12'($signed(5'(r.queue_level)) + 5'sd1) * 12'(quantum_step);
    promote = r.queue_level < 0 ||
              $signed({1'b0, 12'(r.burst_used)}) >= $signed({1'b0, quantum}) ||
              (r.queue_level < -1);
    lvl_p = promote ? 5'(r.queue_level) + 5'sd1 : 5'(r.queue_level);
    if (lvl_p < 0) ins_lvl = '0;
    else if (lvl_p > 5'(LEVEL_COUNT - 1)) ins_lvl = LW'(LEVEL_COUNT - 1);
    else ins_lvl = LW'(lvl_p);
    use_fifo = policy_mode == MODE_MLFQ;
    ent.id = r.task_id;
    ent.prio = r.task_priority;
    ent.rem = r.remaining_time;
    ent.tick = r.last_tick;
    ent.burst = promote ? 8'd0 : r.burst_used;
    // The ordered store keeps the level exactly as it was given.
    ent.level = use_fifo ? 4'(ins_lvl) : r.queue_level;
    any_nonempty = 1'b0;
    pop_lvl = '0;
    lower_busy = 1'b0;
    for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
      if (counts[i] != '0) begin
        any_nonempty = 1'b1;
        pop_lvl = LW'(i);
      end
      if (counts[i] != '0 && $signed(5'(i)) < 5'(r.queue_level)) lower_busy = 1'b1;
    end
  end

  // Ordering test: does a go strictly before b.
  function automatic logic precedes(input logic [1:0] m, input entry_t a, input entry_t b);
    logic [15:0] ka;
    logic [15:0] kb;
    begin
      ka = (m == MODE_SRTF) ? a.rem : 16'(a.prio);
      kb = (m == MODE_SRTF) ? b.rem : 16'(b.prio);
      precedes = (ka != kb) ? (ka < kb) : (a.tick < b.tick);
    end
  endfunction

  // Status to the controller.
  always_comb begin
    sts.need_scan  = r.op == OP_INSERT && !use_fifo && policy_mode != MODE_FCFS &&
                     ord_count != '0 && ord_count < CW'(QUEUE_DEPTH);
    sts.need_shift = !use_fifo && ord_count != '0 &&
                     ((r.op == OP_POP) ||
                      (r.op == OP_INSERT && ord_count < CW'(QUEUE_DEPTH)));
    sts.scan_done  = phase == 2'd1 && (found || idx == ord_count);
    sts.shift_done = (r.op == OP_POP) ? (idx + CW'(1) >= ord_count) : (idx <= pos);
  end

  // Read address: scan and shift both walk idx.
  always_comb begin
    ord_raddr = AW'(idx);
    if (cmd.shift_step && r.op == OP_INSERT) ord_raddr = AW'(idx - CW'(1));
    if (cmd.shift_step && r.op == OP_POP) ord_raddr = AW'(idx + CW'(1));
  end

  always_ff @(posedge clk) begin
    ord_rd <= ord_mem[ord_raddr];
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
  end

  always_ff @(posedge clk) begin
    fifo_rd <= fifo_mem[fifo_raddr];
    if (fifo_we) fifo_mem[fifo_waddr] <= ent;
  end

  // Circular FIFO addresses within each level's slice.
  always_comb begin
    slot_sum = SW'(heads[ins_lvl]) + SW'(counts[ins_lvl]);
    slot = (slot_sum >= SW'(QUEUE_DEPTH)) ? AW'(slot_sum - SW'(QUEUE_DEPTH))
                                          : AW'(slot_sum);
    fifo_raddr = FW'(32'(pop_lvl) * QUEUE_DEPTH + 32'(heads[pop_lvl]));
    fifo_waddr = FW'(32'(ins_lvl) * QUEUE_DEPTH + 32'(slot));
  end

  // Write port control: shifting writes the entry read last cycle into slot idx.
  always_comb begin
    ord_we = 1'b0;
    ord_waddr = AW'(pos);
    ord_wdata = ent;
    fifo_we = 1'b0;
    if (cmd.shift_step && phase == 2'd1) begin
      ord_we = 1'b1;
      ord_wdata = ord_rd;
      ord_waddr = AW'(idx);
    end
    if (cmd.finish && r.op == OP_INSERT) begin
      if (use_fifo) fifo_we = counts[ins_lvl] < CW'(QUEUE_DEPTH);
      else if (ord_count < CW'(QUEUE_DEPTH)) begin
        ord_we = 1'b1;
        ord_waddr = (policy_mode == MODE_FCFS) ? AW'(ord_count) : AW'(pos);
      end
    end
  end

  // Scan, shift and commit sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      ord_count <= '0;
      phase <= '0;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        heads[i] <= '0;
        counts[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        r <= req;
        idx <= '0;
        pos <= '0;
        found <= 1'b0;
        phase <= '0;
      end else if (cmd.scan_step) begin
        // Position found: set up the shift from the tail.
        if (sts.scan_done) begin
          pos <= idx;
          idx <= ord_count;
          phase <= 2'd0;
        end else if (phase == 2'd0) phase <= 2'd1;
        else if (precedes(policy_mode, ent, ord_rd)) found <= 1'b1;
        else begin
          idx <= idx + CW'(1);
          phase <= 2'd0;
        end
      end else if (cmd.shift_step) begin
        if (phase == 2'd0) phase <= 2'd1;
        else begin
          phase <= 2'd0;
          idx <= (r.op == OP_POP) ? idx + CW'(1) : idx - CW'(1);
        end
      end
      if (cmd.finish) begin
        if (r.op == OP_INSERT) begin
          if (use_fifo) begin
            if (counts[ins_lvl] < CW'(QUEUE_DEPTH)) counts[ins_lvl] <= counts[ins_lvl] + CW'(1);
          end else if (ord_count < CW'(QUEUE_DEPTH)) ord_count <= ord_count + CW'(1);
        end else if (r.op == OP_POP) begin
          if (use_fifo) begin
            if (any_nonempty) begin
              heads[pop_lvl] <= (heads[pop_lvl] == AW'(QUEUE_DEPTH - 1)) ? '0
                                : heads[pop_lvl] + AW'(1);
              counts[pop_lvl] <= counts[pop_lvl] - CW'(1);
            end
          end else if (ord_count != '0) ord_count <= ord_count - CW'(1);
        end
      end
    end
  end

  // Yield answer from the captured head or the level counts.
  always_comb begin
    yield_next = 1'b0;
    if (r.op == OP_YIELD) begin
      if (policy_mode == MODE_MLFQ)
        yield_next = lower_busy || r.queue_level < 0 ||
                     $signed({1'b0, 12'(r.burst_used)}) >= $signed({1'b0, quantum});
      else if (policy_mode != MODE_FCFS && ord_count != '0)
        yield_next = precedes(policy_mode, head_q, ent);
    end
  end

  // Head of the ordered store, captured before a pop shifts it away.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      head_q <= ord_mem[0];
    end
    yield_q <= yield_next;
  end

  // Response built from stored state and registered at finish.
  always_comb begin
    rsp_next = '0;
    if (r.op == OP_INSERT) begin
      rsp_next.queue_full = use_fifo ? counts[ins_lvl] >= CW'(QUEUE_DEPTH)
                                     : ord_count >= CW'(QUEUE_DEPTH);
    end else if (r.op == OP_POP) begin
      if (use_fifo && any_nonempty) begin
        rsp_next.task_valid = 1'b1;
        rsp_next.out_task_id = fifo_rd.id;
        rsp_next.out_priority = fifo_rd.prio;
        rsp_next.out_remaining = fifo_rd.rem;
        rsp_next.out_last_tick = fifo_rd.tick;
        rsp_next.out_burst_used = fifo_rd.burst;
        rsp_next.out_level = fifo_rd.level;
      end else if (!use_fifo && ord_count != '0) begin
        rsp_next.task_valid = 1'b1;
        rsp_next.out_task_id = head_q.id;
        rsp_next.out_priority = head_q.prio;
        rsp_next.out_remaining = head_q.rem;
        rsp_next.out_last_tick = head_q.tick;
        rsp_next.out_level = head_q.level;
      end
    end else if (r.op == OP_YIELD) begin
      rsp_next.give_way = yield_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) rsp <= rsp_next;
  end

endmodule

>>> hdl/mrqs_ctrl.sv
module mrqs_ctrl
  import mrqs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_DONE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Accept when idle, or when the held response leaves this cycle.
  assign in_stall  = !(state == S_IDLE || (state == S_OUT && !out_stall));
  assign out_valid = state == S_OUT;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        // Wait for memory reads of the head entries.
        if (sts.need_scan) state_next = S_SCAN;
        else if (sts.need_shift) state_next = S_SHIFT;
        else state_next = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.shift_done) state_next = S_DONE;
        else cmd.shift_step = 1'b1;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (in_valid) begin
            cmd.load = 1'b1;
            state_next = S_PREP;
          end else state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

>>> hdl/multimode_ready_queue_scheduler.sv
// Ready queue scheduler with four policies chosen by policy_mode: first come
// first served, shortest remaining, priority and multilevel feedback. One
// request gives one response, and requests are taken one at a time. Feedback
// inserts and pops, yield queries, inserts into an empty or full store and the
// unused op code need neither a scan nor a shift; a first come first served
// insert into a non-empty store passes the shift state without moving an
// entry. An ordered insert compares the entries ahead of its place and moves
// those behind it one slot down, one entry at a time, because the walking
// read port gives a single entry per read. An ordered pop moves the entries
// behind the head up. Response stalls hold a finished response in place.
// Configure only while idle.
module multimode_ready_queue_scheduler
  import mrqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDefault,
  parameter int LEVEL_COUNT = LevelCountDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  req_t       in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output rsp_t       out_data,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [1:0] policy_mode;
  logic [7:0] quantum_step;
  cmd_t       cmd;
  sts_t       sts;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode  <= MODE_FCFS;
      quantum_step <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLICY_MODE:  policy_mode  <= cfg_data[1:0];
        CFG_QUANTUM_STEP: quantum_step <= cfg_data;
        default: ;
      endcase
    end
  end

  mrqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mrqs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .policy_mode  (policy_mode),
    .quantum_step (quantum_step),
    .req          (in_data),
    .cmd          (cmd),
    .sts          (sts),
    .rsp          (out_data)
  );

endmodule
